[rtl/text_view_line_filter_macros.svh]
// Assertion macros used by the checker file.
`ifndef TEXT_VIEW_LINE_FILTER_MACROS_SVH
`define TEXT_VIEW_LINE_FILTER_MACROS_SVH

// Check cons in the cycle after ante, outside reset.
`define TVLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in the cycle after a reset edge.
`define TVLF_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

[rtl/tvlf_pkg.sv]
package tvlf_pkg;

  localparam int TVLF_NUMBER_DIGITS = 6;
  localparam int TVLF_QUEUE_DEPTH   = 4;
  localparam int TVLF_CFG_ADDR_W    = 3;

  typedef logic [TVLF_CFG_ADDR_W-1:0] tvlf_cfg_idx_t;

  localparam tvlf_cfg_idx_t CFG_NUMBER_ALL       = 3'd0;
  localparam tvlf_cfg_idx_t CFG_NUMBER_NONBLANK  = 3'd1;
  localparam tvlf_cfg_idx_t CFG_SQUEEZE_BLANK    = 3'd2;
  localparam tvlf_cfg_idx_t CFG_SHOW_ENDS        = 3'd3;
  localparam tvlf_cfg_idx_t CFG_SHOW_TABS        = 3'd4;
  localparam tvlf_cfg_idx_t CFG_SHOW_NONPRINTING = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_CTRL   = 8'h40;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [3:0] BCD_NINE  = 4'd9;
  localparam logic [3:0] BCD_ZERO  = 4'd0;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } tvlf_cfg_t;

  // Body of one rendered item: [$][M-][^]glyph
  typedef struct packed {
    logic       dollar;
    logic       meta;
    logic       caret;
    logic [7:0] glyph;
  } tvlf_body_t;

endpackage

[rtl/text_view_line_filter.sv]
// Renders a text byte stream as cat with its number, squeeze and show options
// would: each input byte yields 0 to NUMBER_DIGITS+5 output bytes (11 with six
// digits); a repeated blank line dropped by squeeze yields none. The input side
// takes one byte per cycle while the four-entry queue between classifier and
// expander has room; the output side sends one byte per cycle while out_tready
// is high, so the output port sets sustained throughput. The first output byte
// of an item passes through the queue and then the registered output stage.
// The last byte of each item's output carries out_tlast. Write the six option
// registers only while the block is idle.
module text_view_line_filter #(
  parameter int NUMBER_DIGITS = tvlf_pkg::TVLF_NUMBER_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tvlf_pkg::TVLF_CFG_ADDR_W-1:0] cfg_addr,
  input  logic                          cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] in_byte
  input  logic                          in_tuser,   // [0] new_stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast
);

  import tvlf_pkg::*;

  localparam int DIG_W   = 8 * NUMBER_DIGITS;
  localparam int ENTRY_W = 1 + DIG_W + $bits(tvlf_body_t);

  tvlf_cfg_t cfg_r;

  logic               push, pop, queue_full, head_valid;
  logic               push_num_en, head_num_en;
  logic [DIG_W-1:0]   push_digits, head_digits;
  tvlf_body_t         push_body, head_body;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NUMBER_ALL:       cfg_r.number_all       <= cfg_wdata;
        CFG_NUMBER_NONBLANK:  cfg_r.number_nonblank  <= cfg_wdata;
        CFG_SQUEEZE_BLANK:    cfg_r.squeeze_blank    <= cfg_wdata;
        CFG_SHOW_ENDS:        cfg_r.show_ends        <= cfg_wdata;
        CFG_SHOW_TABS:        cfg_r.show_tabs        <= cfg_wdata;
        CFG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tvlf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .queue_full  (queue_full),
    .push        (push),
    .push_num_en (push_num_en),
    .push_digits (push_digits),
    .push_body   (push_body)
  );

  assign wr_entry = {push_num_en, push_digits, push_body};
  assign {head_num_en, head_digits, head_body} = rd_entry;

  tvlf_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(TVLF_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (wr_entry),
    .pop       (pop),
    .rd_data   (rd_entry),
    .full      (queue_full),
    .not_empty (head_valid)
  );

  tvlf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_num_en (head_num_en),
    .head_digits (head_digits),
    .head_body   (head_body),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

[rtl/tvlf_fifo.sv]
module tvlf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/tvlf_front.sv]
module tvlf_front #(
  parameter int NUMBER_DIGITS = tvlf_pkg::TVLF_NUMBER_DIGITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tvlf_pkg::tvlf_cfg_t          cfg,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,
  input  logic                         in_tuser,
  input  logic                         queue_full,
  output logic                         push,
  output logic                         push_num_en,
  output logic [8*NUMBER_DIGITS-1:0]   push_digits,
  output tvlf_pkg::tvlf_body_t         push_body
);

  import tvlf_pkg::*;

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  logic             at_line_start_r, at_line_start_nxt;
  logic [1:0]       blank_run_r, blank_run_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;

  logic             accept;
  logic             start_eff;
  logic [1:0]       run_eff;
  logic [BCD_W-1:0] bcd_eff, bcd_inc;
  logic             is_nl, is_tab;
  logic             squeeze, numbered;
  logic             started, all_nine, carry;
  logic [3:0]       dv;
  logic [7:0]       low7;

  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;
  assign start_eff = in_tuser ? 1'b1 : at_line_start_r;
  assign run_eff   = in_tuser ? 2'd0 : blank_run_r;
  assign bcd_eff   = in_tuser ? BCD_ONE : bcd_r;
  assign is_nl     = (in_tdata == CH_NL);
  assign is_tab    = (in_tdata == CH_TAB);

  always_comb begin
    blank_run_nxt = run_eff;
    if (start_eff) begin
      if (is_nl) begin
        blank_run_nxt = (run_eff == 2'd2) ? 2'd2 : run_eff + 2'd1;
      end else begin
        blank_run_nxt = 2'd0;
      end
    end
    squeeze  = start_eff && cfg.squeeze_blank && (blank_run_nxt > 2'd1);
    numbered = start_eff && (cfg.number_nonblank ? !is_nl : cfg.number_all);
  end

  // Render digits with leading blanks, most significant first.
  always_comb begin
    started     = 1'b0;
    push_digits = '0;
    for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
      dv = bcd_eff[4*d +: 4];
      if (dv != BCD_ZERO || d == 0) begin
        started = 1'b1;
      end
      push_digits[8*(NUMBER_DIGITS-1-d) +: 8] = started ? {ASCII_DIGIT_HI, dv} : CH_SPACE;
    end
  end

  // Saturating BCD increment.
  always_comb begin
    all_nine = 1'b1;
    carry    = 1'b1;
    bcd_inc  = bcd_eff;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (bcd_eff[4*d +: 4] != BCD_NINE) begin
        all_nine = 1'b0;
      end
    end
    if (!all_nine) begin
      for (int d = 0; d < NUMBER_DIGITS; d++) begin
        if (carry) begin
          if (bcd_eff[4*d +: 4] == BCD_NINE) begin
            bcd_inc[4*d +: 4] = BCD_ZERO;
          end else begin
            bcd_inc[4*d +: 4] = bcd_eff[4*d +: 4] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    push_body = '0;
    low7      = {1'b0, in_tdata[6:0]};
    if (is_tab && cfg.show_tabs) begin
      push_body.caret = 1'b1;
      push_body.glyph = CH_I;
    end else begin
      push_body.dollar = is_nl && cfg.show_ends;
      push_body.glyph  = in_tdata;
      if (cfg.show_nonprinting && !is_nl && !is_tab) begin
        push_body.meta  = in_tdata[7];
        push_body.glyph = low7;
        if (low7 inside {[8'd1:8'd31]}) begin
          push_body.caret = 1'b1;
          push_body.glyph = low7 + CH_CTRL;
        end else if (low7 == CH_DEL) begin
          push_body.caret = 1'b1;
          push_body.glyph = CH_QMARK;
        end else if (low7 == CH_NUL) begin
          push_body.glyph = CH_NUL;
        end
      end
    end
  end

  assign push        = accept && !squeeze;
  assign push_num_en = numbered;

  always_comb begin
    at_line_start_nxt = at_line_start_r;
    bcd_nxt           = bcd_r;
    if (accept) begin
      at_line_start_nxt = is_nl;
      bcd_nxt           = (numbered && !squeeze) ? bcd_inc : bcd_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      blank_run_r     <= 2'd0;
      bcd_r           <= BCD_ONE;
    end else begin
      at_line_start_r <= at_line_start_nxt;
      bcd_r           <= bcd_nxt;
      if (accept) begin
        blank_run_r <= blank_run_nxt;
      end
    end
  end

endmodule

[rtl/tvlf_back.sv]
module tvlf_back #(
  parameter int NUMBER_DIGITS = tvlf_pkg::TVLF_NUMBER_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  logic                        head_num_en,
  input  logic [8*NUMBER_DIGITS-1:0]  head_digits,
  input  tvlf_pkg::tvlf_body_t        head_body,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,
  output logic                        out_tlast
);

  import tvlf_pkg::*;

  localparam int NPOS     = NUMBER_DIGITS + 6;
  localparam int P_TAB    = NUMBER_DIGITS;
  localparam int P_DOLLAR = NUMBER_DIGITS + 1;
  localparam int P_M      = NUMBER_DIGITS + 2;
  localparam int P_DASH   = NUMBER_DIGITS + 3;
  localparam int P_CARET  = NUMBER_DIGITS + 4;
  localparam int P_GLYPH  = NUMBER_DIGITS + 5;

  logic [NPOS-1:0] rem_r, rem_nxt;
  logic            active_r, active_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [7:0]      out_tdata_r, out_tdata_nxt;
  logic            out_tlast_r, out_tlast_nxt;

  logic [NPOS-1:0] full_mask, mask, low_oh, rest;
  logic [7:0]      pos_char [NPOS];
  logic [7:0]      sel_char;
  logic            is_last, go;

  always_comb begin
    full_mask                = '0;
    full_mask[NUMBER_DIGITS-1:0] = {NUMBER_DIGITS{head_num_en}};
    full_mask[P_TAB]         = head_num_en;
    full_mask[P_DOLLAR]      = head_body.dollar;
    full_mask[P_M]           = head_body.meta;
    full_mask[P_DASH]        = head_body.meta;
    full_mask[P_CARET]       = head_body.caret;
    full_mask[P_GLYPH]       = 1'b1;
  end

  always_comb begin
    for (int p = 0; p < NUMBER_DIGITS; p++) begin
      pos_char[p] = head_digits[8*p +: 8];
    end
    pos_char[P_TAB]    = CH_TAB;
    pos_char[P_DOLLAR] = CH_DOLLAR;
    pos_char[P_M]      = CH_M;
    pos_char[P_DASH]   = CH_DASH;
    pos_char[P_CARET]  = CH_CARET;
    pos_char[P_GLYPH]  = head_body.glyph;
  end

  assign mask    = active_r ? rem_r : full_mask;
  assign low_oh  = mask & (~mask + NPOS'(1));
  assign rest    = mask & ~low_oh;
  assign is_last = (rest == '0);
  assign go      = head_valid && (!out_tvalid_r || out_tready);
  assign pop     = go && is_last;

  always_comb begin
    sel_char = '0;
    for (int p = 0; p < NPOS; p++) begin
      if (low_oh[p]) begin
        sel_char = sel_char | pos_char[p];
      end
    end
  end

  always_comb begin
    rem_nxt        = rem_r;
    active_nxt     = active_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (go) begin
      rem_nxt        = rest;
      active_nxt     = !is_last;
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = sel_char;
      out_tlast_nxt  = is_last;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

[rtl/tvlf_checker.sv]
`include "text_view_line_filter_macros.svh"

module tvlf_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [7:0]                           out_tdata,
  input logic                                 out_tlast
);

  `TVLF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output transaction changed")
  `TVLF_ASSERT_AFTER_RESET(a_reset_out_idle, !out_tvalid, "output valid right after reset")
  `TVLF_ASSERT_AFTER_RESET(a_reset_in_ready, in_tready, "input not ready right after reset")

endmodule

bind text_view_line_filter tvlf_checker u_tvlf_checker (.*);
